@@ rtl/lbt_pkg.sv @@
// Shared types and constants for the leaky-bucket throttle.
`timescale 1ns / 1ps

package lbt_pkg;

   localparam int COUNT_W    = 16;
   localparam int BURST_W    = 16;
   localparam int INTERVAL_W = 40;
   localparam int PROD_W     = COUNT_W + INTERVAL_W;
   localparam int STAMP_W    = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 40;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_NS = 1'b1;

   localparam logic [BURST_W-1:0]    BURST_RESET    = 16'd1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 40'd1000;
   localparam logic signed [STAMP_W-1:0] TEN_YEARS_NS = 64'sd316224000000000000;

   // request classification
   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_DENY    = 2'd1,
      KIND_ALLOW   = 2'd2,
      KIND_CHECK   = 2'd3
   } kind_type;

   // front stage -> bucket stage
   typedef struct packed {
      kind_type                   kind;
      logic signed [STAMP_W-1:0]  now;       // saturated, sign-extended
      logic [PROD_W-1:0]          required;  // count * interval (0 for allow)
      logic [PROD_W-1:0]          slack;     // (burst - count) * interval
   } item_type;

   // bucket stage -> permit stage
   typedef struct packed {
      kind_type                   kind;
      logic                       granted;
      logic signed [STAMP_W-1:0]  base;      // leak time after update
      logic [PROD_W-1:0]          add;
   } verdict_type;

endpackage

@@ rtl/lbt_front.sv @@
// Input stage: time saturation, request classification and the interval products.
`timescale 1ns / 1ps

module lbt_front #(
   parameter int TIME_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lbt_pkg::COUNT_W-1:0]          req_count,
   input  logic signed [lbt_pkg::STAMP_W-1:0]   req_now,
   input  logic [lbt_pkg::BURST_W-1:0]          burst,
   input  logic [lbt_pkg::INTERVAL_W-1:0]       interval,
   output logic                                 item_valid,
   input  logic                                 item_ready,
   output lbt_pkg::item_type                    item
);
   import lbt_pkg::*;

   localparam logic signed [STAMP_W-1:0] TMAX64 =
      (64'sd1 <<< (TIME_BITS - 1)) - 64'sd1;
   localparam logic signed [STAMP_W-1:0] TMIN64 = ~TMAX64;

   logic                        valid_ff, valid_in;
   item_type                    item_ff, item_in;
   logic [STAMP_W-TIME_BITS:0]  now_hi;
   logic                        in_range;
   logic [BURST_W-1:0]          headroom;
   logic                        take;

   assign req_ready = !valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   assign now_hi   = req_now[STAMP_W-1:TIME_BITS-1];
   assign in_range = (&now_hi) || !(|now_hi);
   assign headroom = burst - req_count;

   always_comb begin
      item_in.now      = in_range ? req_now : (req_now[STAMP_W-1] ? TMIN64 : TMAX64);
      item_in.required = PROD_W'(req_count) * PROD_W'(interval);
      item_in.slack    = PROD_W'(headroom) * PROD_W'(interval);
      if (req_count == '0 ||
          (interval != '0 && burst != '0 && req_count > burst)) begin
         item_in.kind = KIND_INVALID;
      end else if (burst == '0) begin
         item_in.kind = KIND_DENY;
      end else if (interval == '0) begin
         item_in.kind = KIND_ALLOW;
      end else begin
         item_in.kind = KIND_CHECK;
      end
      valid_in = take ? 1'b1 : (item_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // a check request always fits inside the burst and carries a non-zero requirement
   a_check_fits: assert property (@(posedge clock) disable iff (reset)
      valid_ff && item_ff.kind == KIND_CHECK |-> item_ff.slack <= {PROD_W{1'b1}} &&
      item_ff.required != '0)
      else $error("check request with zero requirement");

endmodule

@@ rtl/lbt_bucket.sv @@
// Bucket stage: holds the last-leak time and decides each request.
`timescale 1ns / 1ps

module lbt_bucket #(
   parameter int TIME_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic [lbt_pkg::PROD_W-1:0]     total,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  lbt_pkg::item_type              item,
   output logic                           verdict_valid,
   input  logic                           verdict_ready,
   output lbt_pkg::verdict_type           verdict
);
   import lbt_pkg::*;

   localparam int CMP_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
   localparam logic signed [STAMP_W-1:0] TMIN64 =
      ~((64'sd1 <<< (TIME_BITS - 1)) - 64'sd1);
   localparam logic signed [STAMP_W-1:0] RESET64 =
      (-TEN_YEARS_NS < TMIN64) ? TMIN64 : -TEN_YEARS_NS;
   localparam logic signed [TIME_BITS-1:0] LEAK_RESET = RESET64[TIME_BITS-1:0];

   logic signed [TIME_BITS-1:0] last_ff, last_in;
   logic                        valid_ff, valid_in;
   verdict_type                 verdict_ff, verdict_in;
   logic signed [TIME_BITS-1:0] now_t, last_drain, last_step;
   logic signed [TIME_BITS:0]   gap;
   logic [CMP_W-1:0]            gap_u;
   logic                        ahead, pass, drained, grant, take;

   assign item_ready = !valid_ff || verdict_ready;
   assign take       = item_valid && item_ready;

   assign now_t   = item.now[TIME_BITS-1:0];
   assign gap     = {now_t[TIME_BITS-1], now_t} - {last_ff[TIME_BITS-1], last_ff};
   assign ahead   = !gap[TIME_BITS];
   assign gap_u   = CMP_W'(gap[TIME_BITS-1:0]);
   assign pass    = ahead && (gap_u >= CMP_W'(item.required));
   assign drained = gap_u >= CMP_W'(total);
   assign grant   = (item.kind == KIND_CHECK) && pass;

   // restart at or below now when fully drained, else step by the requirement
   assign last_drain = now_t - TIME_BITS'(item.slack);
   assign last_step  = last_ff + TIME_BITS'(item.required);

   always_comb begin
      last_in = last_ff;
      if (clear) begin
         last_in = LEAK_RESET;
      end else if (take && grant) begin
         last_in = drained ? last_drain : last_step;
      end
      verdict_in.kind     = item.kind;
      verdict_in.granted  = grant || (item.kind == KIND_ALLOW);
      verdict_in.base     = STAMP_W'(grant ? (drained ? last_drain : last_step) : last_ff);
      verdict_in.add      = item.required;
      valid_in = take ? 1'b1 : (verdict_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= LEAK_RESET;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         verdict_ff <= verdict_in;
      end
   end

   assign verdict_valid = valid_ff;
   assign verdict       = verdict_ff;

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      clear |=> last_ff == LEAK_RESET)
      else $error("leak time not restarted by config write");

   a_leak_moves_on_grant: assert property (@(posedge clock) disable iff (reset)
      !$stable(last_ff) |-> $past(reset) || $past(clear) || $past(take && grant))
      else $error("leak time moved without a grant");

   a_leak_not_ahead: assert property (@(posedge clock) disable iff (reset)
      take && grant && !clear |-> last_in <= now_t)
      else $error("granted leak time passes request time");

endmodule

@@ rtl/lbt_permit.sv @@
// Result stage: saturating next-permit sum and the result register.
`timescale 1ns / 1ps

module lbt_permit #(
   parameter int TIME_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 verdict_valid,
   output logic                                 verdict_ready,
   input  lbt_pkg::verdict_type                 verdict,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_status,
   output logic                                 rsp_granted,
   output logic                                 rsp_permit_valid,
   output logic signed [lbt_pkg::STAMP_W-1:0]   rsp_permit_ns
);
   import lbt_pkg::*;

   localparam int CMP_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
   localparam int SUM_W = CMP_W + 2;
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      (SUM_W'(1) << (TIME_BITS - 1)) - SUM_W'(1);

   logic                         valid_ff, valid_in, take;
   logic                         status_ff, status_in;
   logic                         granted_ff, granted_in;
   logic                         pvalid_ff, pvalid_in;
   logic signed [STAMP_W-1:0]    permit_ff, permit_in;
   logic signed [TIME_BITS-1:0]  base_t, next_t;
   logic signed [SUM_W-1:0]      sum;

   assign verdict_ready = !valid_ff || rsp_ready;
   assign take          = verdict_valid && verdict_ready;

   assign base_t = verdict.base[TIME_BITS-1:0];
   assign sum    = SUM_W'(base_t) + SUM_W'(verdict.add);
   assign next_t = (sum > SUM_MAX) ? SUM_MAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];

   always_comb begin
      status_in  = 1'b0;
      granted_in = 1'b0;
      pvalid_in  = 1'b0;
      permit_in  = '0;
      case (verdict.kind)
         KIND_INVALID: begin
            status_in = 1'b1;
         end
         KIND_DENY: begin
            status_in = 1'b0;
         end
         KIND_ALLOW, KIND_CHECK: begin
            granted_in = verdict.granted;
            pvalid_in  = 1'b1;
            permit_in  = STAMP_W'(next_t);
         end
         default: begin
            status_in = 1'b0;
         end
      endcase
      valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         pvalid_ff  <= pvalid_in;
         permit_ff  <= permit_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted      = granted_ff;
   assign rsp_permit_valid = pvalid_ff;
   assign rsp_permit_ns    = permit_ff;

   a_grant_is_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && granted_ff |-> !status_ff && pvalid_ff)
      else $error("grant on invalid or unscheduled result");

endmodule

@@ rtl/leaky_bucket_throttle_core.sv @@
// Top level of the leaky-bucket throttle: config registers and stage wiring.
`timescale 1ns / 1ps

// Leaky-bucket (GCRA) throttle. Each request item carries an action count and
// the current time in ns; the result item says whether the actions are granted
// now and the earliest time a request of the same count could pass. Items flow
// through three registered stages (input, bucket decision, result); one is
// accepted every clock unless the result side stalls, the rate being set by the
// single last-leak-time register, read, compared and rewritten once per cycle
// in the bucket stage. Each stage stalls only when its own register is full and
// the next one will not take it, so bubbles collapse under backpressure.
// burst_limit (index 0) and interval_ns (index 1) are csr registers; the user
// must write them only while no item is in flight, the core does not enforce
// it. Any write restarts the leak time at minus ten years (clamped to the time
// range). A burst of 0 denies all, even with an interval of 0, which
// otherwise grants all. Times are saturated to a signed TIME_BITS range.
module leaky_bucket_throttle_core #(
   parameter int TIME_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // config write port
   input  logic                                 csr_we,
   input  logic [lbt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lbt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // request items
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lbt_pkg::REQ_DATA_W-1:0]       req_tdata,  // action_count, now_ns
   // result items
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lbt_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // granted, next_permit_ns, pad
   output logic [lbt_pkg::RSP_USER_W-1:0]       rsp_tuser   // status, next_permit_valid
);
   import lbt_pkg::*;

   logic [BURST_W-1:0]        burst_ff, burst_in;
   logic [INTERVAL_W-1:0]     interval_ff, interval_in;
   logic [PROD_W-1:0]         total_ff, total_in;

   logic                      item_valid, item_ready;
   item_type                  item;
   logic                      verdict_valid, verdict_ready;
   verdict_type               verdict;

   logic                      rsp_status, rsp_granted, rsp_permit_valid;
   logic signed [STAMP_W-1:0] rsp_permit_ns;

   // config registers; the user must write only while the pipe is empty, not enforced
   always_comb begin
      burst_in    = burst_ff;
      interval_in = interval_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BURST_LIMIT: burst_in    = csr_wdata[BURST_W-1:0];
            CSR_INTERVAL_NS: interval_in = csr_wdata[INTERVAL_W-1:0];
            default:         burst_in    = burst_ff;
         endcase
      end
   end

   // full-bucket span, refreshed every cycle from the settled registers
   assign total_in = PROD_W'(burst_ff) * PROD_W'(interval_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff    <= BURST_RESET;
         interval_ff <= INTERVAL_RESET;
      end else begin
         burst_ff    <= burst_in;
         interval_ff <= interval_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   lbt_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_count  (req_tdata[COUNT_W-1:0]),
      .req_now    (req_tdata[COUNT_W +: STAMP_W]),
      .burst      (burst_ff),
      .interval   (interval_ff),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   lbt_bucket #(
      .TIME_BITS (TIME_BITS)
   ) u_bucket (
      .clock         (clock),
      .reset         (reset),
      .clear         (csr_we),
      .total         (total_ff),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .verdict_valid (verdict_valid),
      .verdict_ready (verdict_ready),
      .verdict       (verdict)
   );

   lbt_permit #(
      .TIME_BITS (TIME_BITS)
   ) u_permit (
      .clock            (clock),
      .reset            (reset),
      .verdict_valid    (verdict_valid),
      .verdict_ready    (verdict_ready),
      .verdict          (verdict),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_status       (rsp_status),
      .rsp_granted      (rsp_granted),
      .rsp_permit_valid (rsp_permit_valid),
      .rsp_permit_ns    (rsp_permit_ns)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_permit_ns, rsp_granted});
   assign rsp_tuser = {rsp_permit_valid, rsp_status};

endmodule

@@ test/leaky_bucket_throttle_core_tb.sv @@
// Self-checking testbench for the leaky-bucket throttle core.
`timescale 1ns / 1ps

// Drives request items on the req_ stream and checks every result item on the
// rsp_ stream against an in-bench model of the bucket.
//
// Flow:
//   - a directed table walks reset values, invalid counts, deny-all, allow-all,
//     requests earlier than the last leak and saturated permit times; the rows
//     whose answer is obvious carry it typed in, the rest use the model
//   - nine random phases follow, each with its own burst/interval setting and
//     one of three idle patterns on the two streams
// Config writes only happen once every pending result is back and the
// DRAIN_CYCLES wait is over, since the core holds items in three pipeline stages.
module leaky_bucket_throttle_core_tb;

   import lbt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 5;    // pipeline is 3 deep
   localparam int PHASE_ITEMS    = 211;  // 9 phases, ~1900 items

   localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
   localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
   localparam logic signed [STAMP_W+1:0] STAMP_TOP = {3'b000, {(STAMP_W-1){1'b1}}};
   localparam logic signed [79:0]        WIDE_MIN  = -(80'sd1 <<< (STAMP_W-1));
   localparam logic signed [79:0]        WIDE_MAX  = (80'sd1 <<< (STAMP_W-1)) - 80'sd1;
   localparam logic [INTERVAL_W-1:0]     INTERVAL_TOP = {INTERVAL_W{1'b1}};

   // one result item, decoded
   typedef struct packed {
      logic                      status;
      logic                      granted;
      logic                      permit_valid;
      logic signed [STAMP_W-1:0] permit_ns;
   } permit_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      csr_idx;
      logic [CSR_DATA_W-1:0]     csr_val;
      logic [COUNT_W-1:0]        count;
      logic signed [STAMP_W-1:0] now;
      logic                      typed;
      permit_type                answer;
   } step_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // action_count, now_ns
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // granted, next_permit_ns, pad
   logic [RSP_USER_W-1:0]   rsp_tuser;   // status, next_permit_valid

   // bucket model state
   logic [BURST_W-1:0]        burst_limit;
   logic [INTERVAL_W-1:0]     interval_ns;
   logic signed [STAMP_W-1:0] leak_ns;

   permit_type pending_permits[$];
   step_type   steps[$];
   int         error_count  = 0;
   int         stall_cycles = 0;
   int         tx_idle_pct;
   int         rx_idle_pct;

   leaky_bucket_throttle_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Bucket decision for one request; updates leak_ns on a grant.
   function automatic permit_type judge_request(input logic [COUNT_W-1:0] count,
                                                input logic signed [STAMP_W-1:0] now);
      permit_type                r;
      logic signed [STAMP_W+1:0] gap;
      logic signed [STAMP_W+1:0] need;
      logic signed [STAMP_W+1:0] total;
      logic signed [STAMP_W+1:0] add;
      logic signed [STAMP_W+1:0] next;
      r = '0;
      if (count == 0 ||
          (interval_ns != 0 && burst_limit != 0 && count > burst_limit)) begin
         r.status = 1'b1;
         return r;
      end
      if (burst_limit == 0)
         return r;   // deny all
      need  = count * interval_ns;
      total = burst_limit * interval_ns;
      if (interval_ns == 0) begin
         r.granted = 1'b1;   // allow all, bucket untouched
         add = '0;
      end else begin
         gap = now - leak_ns;
         if (gap >= need) begin
            r.granted = 1'b1;
            // drained bucket restarts from now, else leak advances by need
            if (gap >= total)
               leak_ns = now - (total - need);
            else
               leak_ns = leak_ns + need;
         end
         add = need;
      end
      next = leak_ns + add;
      r.permit_valid = 1'b1;
      r.permit_ns = (next > STAMP_TOP) ? STAMP_MAX : next[STAMP_W-1:0];
      return r;
   endfunction

   function automatic void item_row(input logic [COUNT_W-1:0] count,
                                    input logic signed [STAMP_W-1:0] now,
                                    input logic typed, input permit_type answer);
      step_type s;
      s.kind    = ROW_ITEM;
      s.csr_idx = '0;
      s.csr_val = '0;
      s.count   = count;
      s.now     = now;
      s.typed   = typed;
      s.answer  = answer;
      steps.push_back(s);
   endfunction

   function automatic void csr_row(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      step_type s;
      s.kind    = ROW_CSR;
      s.csr_idx = idx;
      s.csr_val = val;
      s.count   = '0;
      s.now     = '0;
      s.typed   = 1'b0;
      s.answer  = '0;
      steps.push_back(s);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with req_tvalid still high, so the next item can follow back to back.
   task automatic send_request(input logic [COUNT_W-1:0] count,
                               input logic signed [STAMP_W-1:0] now,
                               input logic typed, input permit_type answer);
      permit_type predicted;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, count};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = judge_request(count, now);
      pending_permits.push_back(typed ? answer : predicted);
      @(negedge clock);
   endtask

   // Stop sending, let every pending result come back, then let the pipe empty.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_permits.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BURST_LIMIT)
         burst_limit = val[BURST_W-1:0];
      else
         interval_ns = val[INTERVAL_W-1:0];
      leak_ns = -TEN_YEARS_NS;   // any write restarts the bucket
   endtask

   // Random request that mostly lands near the current leak time, so grants,
   // denials and bucket restarts all show up.
   task automatic send_random_request();
      logic [COUNT_W-1:0]        count;
      logic signed [STAMP_W-1:0] now;
      logic signed [79:0]        need;
      logic signed [79:0]        total;
      logic signed [79:0]        t;
      int                        pick;
      int                        jitter;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         count = '0;
      else if (pick < 8)
         count = COUNT_W'($urandom_range(0, 65535));
      else if (burst_limit == 0)
         count = COUNT_W'($urandom_range(1, 65535));
      else if (pick < 12 && burst_limit < 16'hFFFF)
         count = COUNT_W'($urandom_range(burst_limit + 1, 65535));
      else if (pick < 60)
         count = COUNT_W'($urandom_range(1, (burst_limit < 4) ? burst_limit : 4));
      else
         count = COUNT_W'($urandom_range(1, burst_limit));

      need  = count * interval_ns;
      total = burst_limit * interval_ns;
      pick  = $urandom_range(0, 99);
      if (pick < 8) begin
         t = '0;
         now = {$urandom, $urandom};
      end else begin
         if (pick < 18) begin
            jitter = $urandom_range(0, 2);
            t = leak_ns + need - jitter;   // right at the grant edge
         end else if (pick < 28) begin
            jitter = $urandom_range(0, 4);
            t = leak_ns + total + jitter - 2;   // right at the drain edge
         end else if (pick < 36) begin
            jitter = $urandom_range(1, 100000);
            t = leak_ns - jitter;   // before the last leak
         end else begin
            jitter = $urandom_range(0, 150);
            t = leak_ns + (need * jitter) / 100;
         end
         if (t < WIDE_MIN)
            t = WIDE_MIN;
         if (t > WIDE_MAX)
            t = WIDE_MAX;
         now = t[STAMP_W-1:0];
      end
      send_request(count, now, 1'b0, '0);
   endtask

   // Result checker: oldest expectation against each accepted result item.
   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      permit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_permits.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0h/%0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_permits.pop_front();
            check_field("status", want.status, rsp_tuser[0]);
            check_field("granted", want.granted, rsp_tdata[0]);
            check_field("next_permit_valid", want.permit_valid, rsp_tuser[1]);
            check_field("next_permit_ns", want.permit_ns, rsp_tdata[STAMP_W:1]);
         end
      end
   end

   // Receiver stalls at random.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

   // Watchdog: too long without any item moving on either stream.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      permit_type p;
      clock        = 1'b0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      tx_idle_pct  = 33;
      rx_idle_pct  = 73;
      burst_limit  = BURST_RESET;
      interval_ns  = INTERVAL_RESET;
      leak_ns      = -TEN_YEARS_NS;

      // Directed table; reset state is burst 1, interval 1000.
      p = '{1'b1, 1'b0, 1'b0, 64'sd0};
      item_row(16'd0, 64'sd0, 1'b1, p);                    // zero count
      item_row(16'd2, 64'sd0, 1'b1, p);                    // count above burst
      p = '{1'b0, 1'b0, 1'b1, -TEN_YEARS_NS + 64'sd1000};
      item_row(16'd1, STAMP_MIN, 1'b1, p);                 // before last leak
      p = '{1'b0, 1'b1, 1'b1, 64'sd1000};
      item_row(16'd1, 64'sd0, 1'b1, p);                    // drained, restart at now
      item_row(16'd1, 64'sd500, 1'b0, '0);                 // too soon
      p = '{1'b0, 1'b1, 1'b1, STAMP_MAX};
      item_row(16'd1, STAMP_MAX, 1'b1, p);                 // permit saturates
      csr_row(CSR_BURST_LIMIT, 40'd0);                     // deny all
      p = '{1'b0, 1'b0, 1'b0, 64'sd0};
      item_row(16'd1, 64'sd0, 1'b1, p);
      item_row(16'hFFFF, STAMP_MAX, 1'b1, p);
      item_row(16'd0, 64'sd0, 1'b1, '{1'b1, 1'b0, 1'b0, 64'sd0});
      csr_row(CSR_INTERVAL_NS, 40'd0);                     // deny all wins over allow
      item_row(16'd5, 64'sd7, 1'b1, p);
      csr_row(CSR_BURST_LIMIT, 40'd65535);                 // allow all
      p = '{1'b0, 1'b1, 1'b1, -TEN_YEARS_NS};
      item_row(16'hFFFF, -64'sd1, 1'b1, p);
      csr_row(CSR_BURST_LIMIT, 40'd3);
      item_row(16'd100, 64'sd0, 1'b1, p);                  // above burst still allowed
      csr_row(CSR_INTERVAL_NS, INTERVAL_TOP);
      item_row(16'd3, STAMP_MAX, 1'b0, '0);
      item_row(16'd1, 64'sd0, 1'b0, '0);
      item_row(16'd4, 64'sd0, 1'b1, '{1'b1, 1'b0, 1'b0, 64'sd0});
      csr_row(CSR_INTERVAL_NS, 40'd1);
      item_row(16'd1, -TEN_YEARS_NS, 1'b0, '0);
      item_row(16'd2, -TEN_YEARS_NS + 64'sd2, 1'b0, '0);   // partial leak
      item_row(16'd3, STAMP_MIN, 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steps[i]) begin
         if (steps[i].kind == ROW_CSR)
            write_csr(steps[i].csr_idx, steps[i].csr_val);
         else
            send_request(steps[i].count, steps[i].now, steps[i].typed, steps[i].answer);
      end

      // Random phases: three idle patterns, each over three settings.
      for (int phase = 0; phase < 9; phase++) begin
         logic [BURST_W-1:0]    b;
         logic [INTERVAL_W-1:0] iv;
         case (phase)
            0: begin b = BURST_RESET; iv = INTERVAL_RESET; end
            1: begin b = 16'hFFFF;    iv = INTERVAL_TOP;   end
            2: begin b = 16'd0;       iv = 40'd5000;       end
            3: begin b = 16'd200;     iv = 40'd0;          end
            4: begin b = 16'd8;       iv = 40'd37;         end
            5: begin b = 16'hFFFF;    iv = 40'd1;          end
            default: begin
               b  = BURST_W'($urandom_range(1, 64));
               iv = INTERVAL_W'($urandom_range(1, 5000));
            end
         endcase
         write_csr(CSR_BURST_LIMIT, {{(CSR_DATA_W-BURST_W){1'b0}}, b});
         write_csr(CSR_INTERVAL_NS, iv);
         case (phase / 3)
            0: begin tx_idle_pct = 33; rx_idle_pct = 73; end
            1: begin tx_idle_pct = 73; rx_idle_pct = 33; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         repeat (PHASE_ITEMS) send_random_request();
      end

      wait_drained();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
